### rtl/spq_pkg.sv
// Package: shared constants and types of the stable priority queue.
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int DATA_BITS = 32;
  localparam int PRIO_BITS = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic signed [PRIO_BITS-1:0] prio;
    logic [DATA_BITS-1:0]        data;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

### rtl/spq_in_if.sv
// Interface: input channel carrying push and pop transactions.
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [31:0]        item_data;
  logic signed [15:0] item_priority;

  modport source (output valid, output operation, output item_data, output item_priority,
                  input ready);
  modport sink (input valid, input operation, input item_data, input item_priority,
                output ready);
endinterface

### rtl/spq_out_if.sv
// Interface: result channel carrying the head report after each transaction.
interface spq_out_if;
  logic               valid;
  logic               ready;
  logic               head_valid;
  logic [31:0]        head_data;
  logic signed [15:0] head_priority;
  logic [4:0]         entry_count;
  logic               push_dropped;

  modport source (output valid, output head_valid, output head_data, output head_priority,
                  output entry_count, output push_dropped, input ready);
  modport sink (input valid, input head_valid, input head_data, input head_priority,
                input entry_count, input push_dropped, output ready);
endinterface

### rtl/spq_cell.sv
// Cell: one slot of the sorted chain, with its compare and neighbor shift.
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  spq_pkg::entry_t     new_entry,
  input  logic                left_keep,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  output logic                keep,
  output spq_pkg::entry_t     entry
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign keep  = occupied && (entry_r.prio <= new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (left_keep) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end
endmodule

### rtl/stable_priority_queue_core.sv
// Top level: stable priority queue built as a chain of sorting cells.
// Holds up to DEPTH entries sorted by signed priority, lowest first, equal priorities
// in arrival order. For every push or pop transaction all cells compare the
// new priority in parallel and shift toward the tail (push) or the head (pop) at once,
// so a new transaction is taken in every cycle while the result slot is free or being
// drained. Each transaction yields one result reporting the head entry, occupancy and
// whether a push to a full queue was dropped; a pop on an empty queue changes nothing.
module stable_priority_queue_core (
  input  logic             clk,
  input  logic             rst_n,
  spq_in_if.sink           in_chan,
  spq_out_if.source        out_chan
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             dropped_r;
  logic             dropped_nxt;

  logic             accept;
  logic             full;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           cells   [DEPTH];
  logic             keeps   [DEPTH];
  logic             occ     [DEPTH];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = (count_r == CNT_W'(DEPTH));

  assign new_entry.prio = in_chan.item_priority;
  assign new_entry.data = DATA_BITS'(in_chan.item_data);

  assign ctrl.push = accept && (in_chan.operation == OP_PUSH) && !full;
  assign ctrl.pop  = accept && (in_chan.operation == OP_POP) && (count_r != '0);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign occ[g] = (CNT_W'(g) < count_r);
      if (g == 0) begin : g_head
        spq_cell u_cell (
          .clk         (clk),
          .ctrl        (ctrl),
          .occupied    (occ[g]),
          .new_entry   (new_entry),
          .left_keep   (1'b1),
          .left_entry  (new_entry),
          .right_entry (cells[g+1]),
          .keep        (keeps[g]),
          .entry       (cells[g])
        );
      end else if (g == DEPTH - 1) begin : g_tail
        spq_cell u_cell (
          .clk         (clk),
          .ctrl        (ctrl),
          .occupied    (occ[g]),
          .new_entry   (new_entry),
          .left_keep   (keeps[g-1]),
          .left_entry  (cells[g-1]),
          .right_entry (cells[g]),
          .keep        (keeps[g]),
          .entry       (cells[g])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk         (clk),
          .ctrl        (ctrl),
          .occupied    (occ[g]),
          .new_entry   (new_entry),
          .left_keep   (keeps[g-1]),
          .left_entry  (cells[g-1]),
          .right_entry (cells[g+1]),
          .keep        (keeps[g]),
          .entry       (cells[g])
        );
      end
    end
  endgenerate

  always_comb begin
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      dropped_nxt   = (in_chan.operation == OP_PUSH) && full;
      if (ctrl.push) begin
        count_nxt = count_r + 1'b1;
      end else if (ctrl.pop) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dropped_r   <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      dropped_r   <= dropped_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.head_valid    = (count_r != '0);
  assign out_chan.head_data     = (count_r != '0) ? 32'(cells[0].data) : '0;
  assign out_chan.head_priority = (count_r != '0) ? 16'(cells[0].prio) : '0;
  assign out_chan.entry_count   = 5'(count_r);
  assign out_chan.push_dropped  = dropped_r;
endmodule

### sim/spq_checker.sv
// Checker: predicts the head report of each queue transaction and compares the results.
module spq_checker (
  input  logic clk,
  input  logic rst_n,
  spq_in_if    in_chan,
  spq_out_if   out_chan,
  output int   error_count,
  output int   pending
);
  import spq_pkg::*;

  typedef struct packed {
    logic                        head_valid;
    logic [31:0]                 head_data;
    logic signed [PRIO_BITS-1:0] head_priority;
    logic [4:0]                  entry_count;
    logic                        push_dropped;
  } head_report_t;

  entry_t       sorted_entries [DEPTH];
  int           held_count;
  head_report_t expected_reports [$];

  function automatic head_report_t apply_queue_op(input logic op, input logic [31:0] data,
                                                  input logic signed [15:0] prio);
    head_report_t rep;
    int           pos;
    rep = '0;
    if (op == OP_PUSH) begin
      if (held_count >= DEPTH) begin
        rep.push_dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < held_count && $signed(sorted_entries[pos].prio) <= prio) pos++;
        for (int i = held_count; i > pos; i--) sorted_entries[i] = sorted_entries[i - 1];
        sorted_entries[pos].prio = prio;
        sorted_entries[pos].data = data[DATA_BITS-1:0];
        held_count++;
      end
    end else if (held_count > 0) begin
      for (int i = 0; i + 1 < held_count; i++) sorted_entries[i] = sorted_entries[i + 1];
      held_count--;
    end
    if (held_count > 0) begin
      rep.head_valid    = 1'b1;
      rep.head_data     = 32'(sorted_entries[0].data);
      rep.head_priority = sorted_entries[0].prio;
    end
    rep.entry_count = 5'(held_count);
    return rep;
  endfunction

  task automatic log_mismatch(input string what, input head_report_t want,
                              input head_report_t got);
    error_count++;
    if (error_count <= 10)
      $display("%0t mismatch (%s): expected valid=%0b data=%h prio=%0d count=%0d drop=%0b, ",
               $realtime, what, want.head_valid, want.head_data, want.head_priority,
               want.entry_count, want.push_dropped,
               "got valid=%0b data=%h prio=%0d count=%0d drop=%0b",
               got.head_valid, got.head_data, got.head_priority, got.entry_count,
               got.push_dropped);
  endtask

  always @(posedge clk) begin : watch
    head_report_t got;
    head_report_t want;
    if (!rst_n) begin
      held_count = 0;
      expected_reports.delete();
    end else begin
      if (in_chan.valid && in_chan.ready)
        expected_reports.push_back(apply_queue_op(in_chan.operation, in_chan.item_data,
                                                  in_chan.item_priority));
      if (out_chan.valid && out_chan.ready) begin
        got.head_valid    = out_chan.head_valid;
        got.head_data     = out_chan.head_data;
        got.head_priority = out_chan.head_priority;
        got.entry_count   = out_chan.entry_count;
        got.push_dropped  = out_chan.push_dropped;
        if (expected_reports.size() == 0) begin
          log_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_reports.pop_front();
          if (got.head_valid !== want.head_valid || got.head_data !== want.head_data ||
              got.head_priority !== want.head_priority ||
              got.entry_count !== want.entry_count ||
              got.push_dropped !== want.push_dropped)
            log_mismatch("field", want, got);
        end
      end
    end
    pending = expected_reports.size();
  end
endmodule

### sim/tb.sv
// Testbench top: drives push and pop transactions into the priority queue and gives the verdict.
module tb;
  import spq_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic hold_rx;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   failures;
  int   outstanding;
  int   quiet_cycles;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  stable_priority_queue_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  spq_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_ch),
    .out_chan    (out_ch),
    .error_count (failures),
    .pending     (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready = !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_op(input logic op, input logic [31:0] data,
                         input logic signed [15:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.operation     = op;
    in_ch.item_data     = data;
    in_ch.item_priority = prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int                 burst_left;
    int                 push_pct;
    logic               op;
    logic [31:0]        data;
    logic signed [15:0] prio;
    burst_left = 0;
    push_pct   = 50;
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 4);
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      burst_left--;
      op   = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
      data = $urandom;
      case ($urandom_range(3))
        0: prio = 16'($urandom);
        1: begin
          prio = 16'($urandom_range(6));
          prio = prio - 16'sd3;
        end
        2:       prio = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default: prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      send_op(op, data, prio);
    end
  endtask

  initial begin
    logic signed [15:0] fill_prio;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_PUSH;
    in_ch.item_data     = '0;
    in_ch.item_priority = '0;
    hold_rx             = 1'b0;
    send_idle_pct       = 26;
    recv_idle_pct       = 70;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    send_op(OP_POP, 32'hDEAD_BEEF, 16'sd7);
    send_op(OP_PUSH, 32'h0000_0000, 16'h8000);
    send_op(OP_PUSH, 32'hFFFF_FFFF, 16'h7FFF);
    send_op(OP_PUSH, 32'hAAAA_5555, 16'sd5);
    send_op(OP_PUSH, 32'h5555_AAAA, 16'sd5);
    send_op(OP_PUSH, 32'h1234_5678, 16'sd5);
    send_op(OP_PUSH, 32'h8000_0001, 16'hFFFF);
    send_op(OP_POP, 32'h0, 16'sd0);
    send_op(OP_POP, 32'h0, 16'sd0);
    for (int i = 0; i < 12; i++) begin
      fill_prio = 16'(i);
      fill_prio = fill_prio - 16'sd5;
      send_op(OP_PUSH, 32'h0101_0101 * (i + 1), fill_prio);
    end
    send_op(OP_PUSH, 32'hC0FF_EE00, 16'h8000);
    send_op(OP_POP, 32'h0, 16'sd0);
    send_op(OP_POP, 32'h0, 16'sd0);
    drain_results();

    fork
      begin
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (80) @(posedge clk);
        hold_rx = 1'b0;
      end
    join_none
    run_random(40);
    run_random(160);
    drain_results();

    send_idle_pct = 70;
    recv_idle_pct = 26;
    run_random(200);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(200);
    drain_results();
    repeat (10) @(negedge clk);

    if (failures == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
